FILE: src/onewire_temperature_read_sequencer_defines.svh
// assertion macros for the one-wire temperature read sequencer
`ifndef ONEWIRE_TEMPERATURE_READ_SEQUENCER_DEFINES_SVH
`define ONEWIRE_TEMPERATURE_READ_SEQUENCER_DEFINES_SVH

// checked only outside reset
`define OWTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define OWTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/owts_pkg.sv
package owts_pkg;

    localparam int TICK_W = 20;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TEMP_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERSION    = 3'd6;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef struct packed {
        logic [9:0]  reset_low_ticks;
        logic [9:0]  presence_wait_ticks;
        logic [9:0]  reset_tail_ticks;
        logic [3:0]  slot_low_ticks;
        logic [7:0]  slot_ticks;
        logic [7:0]  byte_gap_ticks;
        logic [19:0] conversion_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_ticks:     10'd600,
        presence_wait_ticks: 10'd100,
        reset_tail_ticks:    10'd30,
        slot_low_ticks:      4'd1,
        slot_ticks:          8'd50,
        byte_gap_ticks:      8'd50,
        conversion_ticks:    20'd800000
    };

    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCRATCH;
        endcase
        return b;
    endfunction

    function automatic logic [TICK_W-1:0] clip_limit(input logic [CFG_DATA_W-1:0] lim);
        logic [31:0] w;
        w = 32'(lim);
        if (w > 32'(TICK_MAX)) begin
            return TICK_MAX;
        end
        return w[TICK_W-1:0];
    endfunction

endpackage

FILE: src/owts_ifs.sv
interface owts_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic wait_conversion;
    logic bus_level;

    modport source (output valid, output start_req, output wait_conversion,
                    output bus_level, input ready);
    modport sink (input valid, input start_req, input wait_conversion,
                  input bus_level, output ready);
endinterface

interface owts_res_if;
    logic                                valid;
    logic                                ready;
    logic                                drive_low;
    logic                                busy_res;
    logic                                done_res;
    logic                                presence_seen;
    logic signed [owts_pkg::TEMP_W-1:0]  temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_seen, output temperature, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence_seen, input temperature, output ready);
endinterface

interface owts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [owts_pkg::CFG_IDX_W-1:0]    index;
    logic [owts_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/owts_cfg_regs.sv
module owts_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    owts_cfg_if.sink        i_cfg,
    output owts_pkg::t_cfg  o_cfg
);

    owts_pkg::t_cfg r_cfg;
    owts_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                owts_pkg::REG_RESET_LOW:     n_cfg.reset_low_ticks     = i_cfg.data[9:0];
                owts_pkg::REG_PRESENCE_WAIT: n_cfg.presence_wait_ticks = i_cfg.data[9:0];
                owts_pkg::REG_RESET_TAIL:    n_cfg.reset_tail_ticks    = i_cfg.data[9:0];
                owts_pkg::REG_SLOT_LOW:      n_cfg.slot_low_ticks      = i_cfg.data[3:0];
                owts_pkg::REG_SLOT:          n_cfg.slot_ticks          = i_cfg.data[7:0];
                owts_pkg::REG_BYTE_GAP:      n_cfg.byte_gap_ticks      = i_cfg.data[7:0];
                owts_pkg::REG_CONVERSION:    n_cfg.conversion_ticks    = i_cfg.data[19:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owts_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: src/onewire_temperature_read_sequencer.sv
// one input transaction is one bus tick and yields exactly one result transaction
// latency: the result is registered and shown the cycle after the tick is taken
// throughput: one tick per cycle unless the sink stalls the single output register
// a read takes two reset sequences, four command bytes, optional conversion and 16 slots
// synchronous active-low reset returns to idle with zero temperature and default timing
module onewire_temperature_read_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owts_in_if.sink     i_in,
    owts_res_if.source  o_res,
    owts_cfg_if.sink    i_cfg
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_SLOT  = 4'd5;
    localparam logic [3:0] PH_WR_GAP   = 4'd6;
    localparam logic [3:0] PH_CONV     = 4'd7;
    localparam logic [3:0] PH_RD_LOW   = 4'd8;
    localparam logic [3:0] PH_RD_SLOT  = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    owts_pkg::t_cfg cfg;

    logic [3:0]                    r_phase,    n_phase;
    logic [owts_pkg::TICK_W-1:0]   r_tick,     n_tick;
    logic [3:0]                    r_bit,      n_bit;
    logic [2:0]                    r_byte,     n_byte;
    logic [15:0]                   r_shift,    n_shift;
    logic                          r_presence, n_presence;
    logic                          r_wait,     n_wait;
    logic [owts_pkg::TEMP_W-1:0]   r_temp,     n_temp;

    logic                          r_out_valid;
    logic                          r_drive, r_busy, r_done, r_pres_out;
    logic [owts_pkg::TEMP_W-1:0]   r_temp_out;

    logic                            accept;
    logic                            drive, busy, done;
    logic [owts_pkg::TICK_W-1:0]     tick_inc;
    logic [owts_pkg::CFG_DATA_W-1:0] lim_raw;
    logic [owts_pkg::TICK_W-1:0]     lim;
    logic                            cnt_done;
    logic [15:0]                     rd_shift;
    logic                            go_gap, go_after, go_tail, go_begin, go_reset;

    owts_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.drive_low     = r_drive;
    assign o_res.busy_res      = r_busy;
    assign o_res.done_res      = r_done;
    assign o_res.presence_seen = r_pres_out;
    assign o_res.temperature   = $signed(r_temp_out);

    // tick limit of the current phase
    always_comb begin
        case (r_phase)
            PH_RST_LOW:              lim_raw = 20'(cfg.reset_low_ticks);
            PH_RST_WAIT:             lim_raw = 20'(cfg.presence_wait_ticks);
            PH_RST_TAIL:             lim_raw = 20'(cfg.reset_tail_ticks);
            PH_WR_LOW, PH_RD_LOW:    lim_raw = 20'(cfg.slot_low_ticks);
            PH_WR_SLOT, PH_RD_SLOT:  lim_raw = 20'(cfg.slot_ticks);
            PH_WR_GAP:               lim_raw = 20'(cfg.byte_gap_ticks);
            PH_CONV:                 lim_raw = cfg.conversion_ticks;
            default:                 lim_raw = '0;
        endcase
    end

    assign lim      = owts_pkg::clip_limit(lim_raw);
    assign tick_inc = (r_tick < owts_pkg::TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign cnt_done = tick_inc >= lim;
    assign rd_shift = (r_tick == '0) ? {i_in.bus_level, r_shift[15:1]} : r_shift;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_wait     = r_wait;
        n_temp     = r_temp;
        drive      = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        go_gap     = 1'b0;
        go_after   = 1'b0;
        go_tail    = 1'b0;
        go_begin   = 1'b0;
        go_reset   = 1'b0;

        case (r_phase)
            PH_RST_LOW: begin
                drive  = 1'b1;
                n_tick = tick_inc;
                if (cnt_done) begin
                    n_tick  = '0;
                    n_phase = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT: begin
                n_tick = tick_inc;
                if (cnt_done) begin
                    n_presence = ~i_in.bus_level;
                    go_tail    = 1'b1;
                end
            end
            PH_RST_TAIL: begin
                n_tick = tick_inc;
                if (cnt_done) begin
                    go_begin = 1'b1;
                end
            end
            PH_WR_LOW, PH_RD_LOW: begin
                drive  = 1'b1;
                n_tick = tick_inc;
                if (cnt_done) begin
                    n_tick  = '0;
                    n_phase = (r_phase == PH_WR_LOW) ? PH_WR_SLOT : PH_RD_SLOT;
                end
            end
            PH_WR_SLOT: begin
                drive  = ~r_shift[0];
                n_tick = tick_inc;
                if (cnt_done) begin
                    n_shift = {1'b0, r_shift[15:1]};
                    if (r_bit >= 4'd7) begin
                        go_gap = 1'b1;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_tick  = '0;
                        n_phase = PH_WR_LOW;
                    end
                end
            end
            PH_WR_GAP: begin
                n_tick = tick_inc;
                if (cnt_done) begin
                    go_after = 1'b1;
                end
            end
            PH_CONV: begin
                n_tick = tick_inc;
                if (cnt_done) begin
                    go_reset = 1'b1;
                end
            end
            PH_RD_SLOT: begin
                n_shift = rd_shift;
                n_tick  = tick_inc;
                if (cnt_done) begin
                    n_tick = '0;
                    if (r_bit >= 4'd15) begin
                        n_temp  = rd_shift;
                        n_bit   = '0;
                        n_phase = PH_DONE;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_phase = PH_RD_LOW;
                    end
                end
            end
            PH_DONE: begin
                busy    = 1'b0;
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                busy    = 1'b0;
                n_phase = PH_IDLE;
                if (i_in.start_req) begin
                    n_wait   = i_in.wait_conversion;
                    n_byte   = '0;
                    n_bit    = '0;
                    go_reset = 1'b1;
                end
            end
        endcase

        // follow-on transitions, in the order they chain
        if (go_gap) begin
            n_tick = '0;
            if (cfg.byte_gap_ticks == '0) begin
                go_after = 1'b1;
            end else begin
                n_phase = PH_WR_GAP;
            end
        end
        if (go_after) begin
            n_byte = r_byte + 1'b1;
            n_tick = '0;
            if (n_byte == 3'd2) begin
                if (r_wait && cfg.conversion_ticks != '0) begin
                    n_phase = PH_CONV;
                end else begin
                    go_reset = 1'b1;
                end
            end else begin
                go_begin = 1'b1;
            end
        end
        if (go_tail) begin
            n_tick = '0;
            if (cfg.reset_tail_ticks == '0) begin
                go_begin = 1'b1;
            end else begin
                n_phase = PH_RST_TAIL;
            end
        end
        if (go_begin) begin
            n_tick = '0;
            n_bit  = '0;
            if (n_byte >= 3'd4) begin
                n_shift = '0;
                n_phase = PH_RD_LOW;
            end else begin
                n_shift = {8'h00, owts_pkg::cmd_byte(n_byte[1:0])};
                n_phase = PH_WR_LOW;
            end
        end
        if (go_reset) begin
            n_tick  = '0;
            n_phase = PH_RST_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_byte      <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_wait      <= 1'b0;
            r_temp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_bit      <= n_bit;
                r_byte     <= n_byte;
                r_shift    <= n_shift;
                r_presence <= n_presence;
                r_wait     <= n_wait;
                r_temp     <= n_temp;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive    <= drive;
            r_busy     <= busy;
            r_done     <= done;
            r_pres_out <= n_presence;
            r_temp_out <= n_temp;
        end
    end

endmodule

FILE: src/owts_checker.sv
`include "onewire_temperature_read_sequencer_defines.svh"

module owts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_drive_low,
    input logic                          i_busy_res,
    input logic                          i_done_res,
    input logic                          i_presence_seen,
    input logic [owts_pkg::TEMP_W-1:0]   i_temperature
);

    // a stalled result transaction keeps its payload
    `OWTS_ASSERT_RST(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_drive_low, i_busy_res, i_done_res, i_presence_seen, i_temperature}), "result changed while stalled")

    // completion pulse comes with the sequence no longer busy
    `OWTS_ASSERT_RST(a_done_not_busy, i_out_valid && i_done_res |-> !i_busy_res, "done while busy")

    // the line is only pulled low during a sequence
    `OWTS_ASSERT_RST(a_drive_busy, i_out_valid && i_drive_low |-> i_busy_res, "drive low while idle")

    // nothing is offered right after reset
    `OWTS_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !i_out_valid, "result valid after reset")

endmodule

bind onewire_temperature_read_sequencer owts_checker u_owts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_drive_low     (o_res.drive_low),
    .i_busy_res      (o_res.busy_res),
    .i_done_res      (o_res.done_res),
    .i_presence_seen (o_res.presence_seen),
    .i_temperature   (o_res.temperature)
);

FILE: test/tb_onewire_temperature_read_sequencer.sv
module tb_onewire_temperature_read_sequencer;
    import owts_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [3:0][7:0] READ_CMDS =
        {CMD_READ_SCRATCH, CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM};
    localparam logic [CFG_DATA_W-1:0] HIGH_BITS = 20'hFFC00;
    localparam int STUCK_LIMIT = 5000;
    localparam int REPORT_MAX = 10;
    localparam int ITEM_TARGET = 1750;
    localparam int READ_TICKS_MAX = 100000;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL, SEQ_WR_LOW, SEQ_WR_SLOT,
        SEQ_WR_GAP, SEQ_CONV, SEQ_RD_LOW, SEQ_RD_SLOT, SEQ_DONE
    } t_seq_phase;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        presence;
        logic [15:0] temperature;
    } t_bus_out;

    logic i_clk;
    logic i_rst_n;

    owts_in_if  in_if();
    owts_res_if res_if();
    owts_cfg_if cfg_if();

    onewire_temperature_read_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // bus sequencer model state
    t_seq_phase      seq_phase = SEQ_IDLE;
    logic [TICK_W-1:0] tick_cnt = '0;
    logic [3:0]      bit_cnt = '0;
    logic [2:0]      byte_idx = '0;
    logic [15:0]     shift_word_q = '0;
    logic            presence_q = 1'b0;
    logic            wait_q = 1'b0;
    logic [15:0]     temp_q = '0;
    t_cfg            timing = CFG_RESET;

    t_bus_out pending_outputs[$];

    int errors = 0;
    int ticks_sent = 0;
    int reads_done = 0;
    int reads_started = 0;
    int cfg_writes = 0;
    int stuck_cycles = 0;
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("error: %s", msg);
        end
    endfunction

    function automatic bit count_reached(input logic [TICK_W-1:0] limit);
        if (tick_cnt < TICK_MAX) begin
            tick_cnt++;
        end
        return tick_cnt >= limit;
    endfunction

    function automatic void start_byte();
        tick_cnt = '0;
        bit_cnt = '0;
        if (byte_idx >= 3'd4) begin
            shift_word_q = '0;
            seq_phase = SEQ_RD_LOW;
        end else begin
            shift_word_q = {8'h00, READ_CMDS[byte_idx[1:0]]};
            seq_phase = SEQ_WR_LOW;
        end
    endfunction

    function automatic void start_reset();
        tick_cnt = '0;
        seq_phase = SEQ_RST_LOW;
    endfunction

    function automatic void start_tail();
        tick_cnt = '0;
        if (timing.reset_tail_ticks == '0) begin
            start_byte();
        end else begin
            seq_phase = SEQ_RST_TAIL;
        end
    endfunction

    function automatic void next_byte();
        byte_idx = byte_idx + 3'd1;
        tick_cnt = '0;
        if (byte_idx == 3'd2) begin
            if (wait_q && timing.conversion_ticks != '0) begin
                seq_phase = SEQ_CONV;
            end else begin
                start_reset();
            end
        end else begin
            start_byte();
        end
    endfunction

    function automatic void start_gap();
        tick_cnt = '0;
        if (timing.byte_gap_ticks == '0) begin
            next_byte();
        end else begin
            seq_phase = SEQ_WR_GAP;
        end
    endfunction

    function automatic t_bus_out model_bus_tick(input bit start, input bit wantw,
                                                input bit level);
        t_bus_out r;
        r.drive_low = 1'b0;
        r.busy = 1'b1;
        r.done = 1'b0;
        case (seq_phase)
            SEQ_RST_LOW: begin
                r.drive_low = 1'b1;
                if (count_reached(timing.reset_low_ticks)) begin
                    tick_cnt = '0;
                    seq_phase = SEQ_RST_WAIT;
                end
            end
            SEQ_RST_WAIT: begin
                if (count_reached(timing.presence_wait_ticks)) begin
                    presence_q = ~level;
                    start_tail();
                end
            end
            SEQ_RST_TAIL: begin
                if (count_reached(timing.reset_tail_ticks)) begin
                    start_byte();
                end
            end
            SEQ_WR_LOW, SEQ_RD_LOW: begin
                r.drive_low = 1'b1;
                if (count_reached(timing.slot_low_ticks)) begin
                    tick_cnt = '0;
                    seq_phase = (seq_phase == SEQ_WR_LOW) ? SEQ_WR_SLOT : SEQ_RD_SLOT;
                end
            end
            SEQ_WR_SLOT: begin
                r.drive_low = ~shift_word_q[0];
                if (count_reached(timing.slot_ticks)) begin
                    shift_word_q = {1'b0, shift_word_q[15:1]};
                    if (bit_cnt >= 4'd7) begin
                        start_gap();
                    end else begin
                        bit_cnt++;
                        tick_cnt = '0;
                        seq_phase = SEQ_WR_LOW;
                    end
                end
            end
            SEQ_WR_GAP: begin
                if (count_reached(timing.byte_gap_ticks)) begin
                    next_byte();
                end
            end
            SEQ_CONV: begin
                if (count_reached(timing.conversion_ticks)) begin
                    start_reset();
                end
            end
            SEQ_RD_SLOT: begin
                if (tick_cnt == '0) begin
                    shift_word_q = {level, shift_word_q[15:1]};
                end
                if (count_reached(timing.slot_ticks)) begin
                    tick_cnt = '0;
                    if (bit_cnt >= 4'd15) begin
                        temp_q = shift_word_q;
                        bit_cnt = '0;
                        seq_phase = SEQ_DONE;
                    end else begin
                        bit_cnt++;
                        seq_phase = SEQ_RD_LOW;
                    end
                end
            end
            SEQ_DONE: begin
                r.busy = 1'b0;
                r.done = 1'b1;
                seq_phase = SEQ_IDLE;
            end
            default: begin
                r.busy = 1'b0;
                seq_phase = SEQ_IDLE;
                if (start) begin
                    wait_q = wantw;
                    byte_idx = '0;
                    bit_cnt = '0;
                    start_reset();
                end
            end
        endcase
        r.presence = presence_q;
        r.temperature = temp_q;
        return r;
    endfunction

    // sensor side of the bus: presence during the reset wait, data bits on read samples
    function automatic bit sensor_level(input bit present, input logic [15:0] word);
        if (seq_phase == SEQ_RST_WAIT) begin
            return ~present;
        end
        if (seq_phase == SEQ_RD_SLOT && tick_cnt == '0) begin
            return word[bit_cnt];
        end
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_send || roll < 70) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_tick(input bit start, input bit wantw, input bit level);
        int gap;
        in_if.valid <= 1'b1;
        in_if.start_req <= start;
        in_if.wait_conversion <= wantw;
        in_if.bus_level <= level;
        do @(posedge i_clk); while (!in_if.ready);
        pending_outputs.push_back(model_bus_tick(start, wantw, level));
        ticks_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_RESET_LOW:     timing.reset_low_ticks = value[9:0];
            REG_PRESENCE_WAIT: timing.presence_wait_ticks = value[9:0];
            REG_RESET_TAIL:    timing.reset_tail_ticks = value[9:0];
            REG_SLOT_LOW:      timing.slot_low_ticks = value[3:0];
            REG_SLOT:          timing.slot_ticks = value[7:0];
            REG_BYTE_GAP:      timing.byte_gap_ticks = value[7:0];
            REG_CONVERSION:    timing.conversion_ticks = value;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] rst_low,
                              input logic [CFG_DATA_W-1:0] pres,
                              input logic [CFG_DATA_W-1:0] tail,
                              input logic [CFG_DATA_W-1:0] slot_low,
                              input logic [CFG_DATA_W-1:0] slot,
                              input logic [CFG_DATA_W-1:0] gap,
                              input logic [CFG_DATA_W-1:0] conv);
        wait_for_outputs();
        cfg_write(REG_RESET_LOW, rst_low);
        cfg_write(REG_PRESENCE_WAIT, pres);
        cfg_write(REG_RESET_TAIL, tail);
        cfg_write(REG_SLOT_LOW, slot_low);
        cfg_write(REG_SLOT, slot);
        cfg_write(REG_BYTE_GAP, gap);
        cfg_write(REG_CONVERSION, conv);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // sensor ticks of a running read until idle or until max_ticks were sent
    task automatic finish_read(input bit present, input logic [15:0] word, input bit noisy,
                               input int max_ticks);
        bit st;
        bit lvl;
        int n;
        n = 0;
        while (seq_phase != SEQ_IDLE && n < max_ticks) begin
            st = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
            lvl = sensor_level(present, word);
            if (noisy && $urandom_range(0, 7) == 0) begin
                lvl = 1'($urandom_range(0, 1));
            end
            send_tick(st, 1'($urandom_range(0, 1)), lvl);
            n++;
        end
    endtask

    // one full temperature read from start to the done tick
    task automatic run_read(input bit wantw, input bit present, input logic [15:0] word,
                            input bit noisy);
        send_tick(1'b1, wantw, 1'($urandom_range(0, 1)));
        reads_started++;
        finish_read(present, word, noisy, READ_TICKS_MAX);
    endtask

    // mostly short lengths, sometimes with bits set above the register width
    function automatic logic [CFG_DATA_W-1:0] rand_len(input int small_max);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom_range(0, small_max));
        if ($urandom_range(0, 9) == 0) begin
            v = v | (CFG_DATA_W'($urandom) & HIGH_BITS);
        end
        return v;
    endfunction

    task automatic test_reset_defaults();
        idle_ticks(8);
        send_tick(1'b1, 1'b0, 1'b1);
        reads_started++;
        finish_read(1'b1, 16'h0550, 1'b0, 12);
        wait_for_outputs();
        cfg_write(REG_RESET_LOW, 20'd1);
        // default presence wait and reset tail, into the first default slot
        finish_read(1'b1, 16'h0550, 1'b0, 140);
        set_timing(20'd1, 20'd1, 20'd0, 20'd1, 20'd1, 20'd0, 20'd0);
        finish_read(1'b1, 16'h0550, 1'b0, READ_TICKS_MAX);
        idle_ticks(3);
    endtask

    task automatic test_minimum_timing();
        set_timing(20'd1, 20'd1, 20'd0, 20'd1, 20'd1, 20'd0, 20'd0);
        run_read(1'b1, 1'b1, 16'h0000, 1'b0);
        run_read(1'b1, 1'b0, 16'hFFFF, 1'b0);
        run_read(1'b0, 1'b1, 16'h8000, 1'b0);
    endtask

    task automatic test_zero_lengths();
        set_timing(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        run_read(1'b1, 1'b1, 16'h1234, 1'b0);
    endtask

    task automatic test_conversion_wait();
        set_timing(20'd2, 20'd3, 20'd1, 20'd1, 20'd2, 20'd1, 20'd37);
        run_read(1'b1, 1'b1, 16'h0191, 1'b0);
        wait_for_outputs();
        cfg_write(REG_CONVERSION, 20'd1);
        run_read(1'b1, 1'b0, 16'h0008, 1'b0);
    endtask

    task automatic test_start_while_busy();
        set_timing(20'd3, 20'd2, 20'd2, 20'd2, 20'd3, 20'd2, 20'd5);
        run_read(1'($urandom_range(0, 1)), 1'b1, 16'($urandom), 1'b1);
    endtask

    task automatic test_register_truncation();
        set_timing(20'hFFC02, 20'hFFC03, 20'hFFC01, 20'hFFFF1, 20'hFFF02, 20'hFFF01,
                   20'hFFFFF);
        cfg_write(REG_UNUSED, 20'hFFFFF);
        quiet_send = 1'b1;
        run_read(1'b0, 1'b1, 16'hF00F, 1'b0);
        quiet_send = 1'b0;
        idle_ticks(4);
    endtask

    task automatic test_random_reads();
        int started_base;
        started_base = reads_started;
        while (ticks_sent < ITEM_TARGET || reads_started == started_base) begin
            if (reads_started == started_base || $urandom_range(0, 3) == 0) begin
                set_timing(rand_len(12), rand_len(12), rand_len(6), rand_len(3), rand_len(4),
                           rand_len(4), CFG_DATA_W'($urandom_range(0, 40)));
            end else if ($urandom_range(0, 7) == 0) begin
                wait_for_outputs();
            end
            quiet_send = ($urandom_range(0, 3) == 0);
            run_read(1'($urandom_range(0, 1)), ($urandom_range(0, 6) != 0), 16'($urandom),
                     ($urandom_range(0, 9) < 3));
            idle_ticks($urandom_range(0, 5));
        end
        quiet_send = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.start_req <= 1'b0;
        in_if.wait_conversion <= 1'b0;
        in_if.bus_level <= 1'b1;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_RESET_LOW;
        cfg_if.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_minimum_timing();
        test_zero_lengths();
        test_conversion_wait();
        test_start_while_busy();
        test_register_truncation();
        test_random_reads();

        wait_for_outputs();
        repeat (10) @(posedge i_clk);
        $display("covered %0d bus ticks, %0d reads started, %0d done pulses checked",
                 ticks_sent, reads_started, reads_done);
        $display("%0d register writes incl. default, zero, minimum and over-wide values; %0d mismatches",
                 cfg_writes, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result sink backpressure
    initial begin
        int hold;
        int roll;
        hold = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 299) == 0) begin
                quiet_recv = ~quiet_recv;
            end
            roll = $urandom_range(0, 99);
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else if (quiet_recv || roll < 80) begin
                res_if.ready <= 1'b1;
            end else if (roll < 97) begin
                hold = $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end else begin
                hold = $urandom_range(10, 60);
                res_if.ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_bus_out want;
        t_bus_out got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.drive_low = res_if.drive_low;
            got.busy = res_if.busy_res;
            got.done = res_if.done_res;
            got.presence = res_if.presence_seen;
            got.temperature = res_if.temperature;
            if (pending_outputs.size() == 0) begin
                flag_error($sformatf("unexpected transaction: drive %0b busy %0b done %0b",
                                     got.drive_low, got.busy, got.done));
            end else begin
                want = pending_outputs.pop_front();
                if (want.drive_low != got.drive_low || want.busy != got.busy
                    || want.done != got.done || want.presence != got.presence
                    || want.temperature != got.temperature) begin
                    flag_error($sformatf({"expected drive %0b busy %0b done %0b presence %0b",
                                          " temp %0d, got drive %0b busy %0b done %0b",
                                          " presence %0b temp %0d"},
                                         want.drive_low, want.busy, want.done, want.presence,
                                         $signed(want.temperature), got.drive_low, got.busy,
                                         got.done, got.presence, $signed(got.temperature)));
                end
                if (want.done) begin
                    reads_done++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
